// File: hdl/fnv_byte_hash_engine_assert.svh
// Assertion macros used by the checker file.
`ifndef FNV_BYTE_HASH_ENGINE_ASSERT_SVH
`define FNV_BYTE_HASH_ENGINE_ASSERT_SVH

// Clocked check, masked while reset is asserted.
`define FNV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define FNV_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hdl/fnv_pkg.sv
package fnv_pkg;

  // config register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_HASH_WIDTH = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_VARIANT    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_INIT_MODE  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SEED_HIGH  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SEED_LOW   = 3'd4;

  // hash width codes (code three behaves as 128-bit)
  localparam logic [1:0] WIDTH_32  = 2'd0;
  localparam logic [1:0] WIDTH_64  = 2'd1;
  localparam logic [1:0] WIDTH_128 = 2'd2;

  // variant codes
  localparam logic VARIANT_FNV1  = 1'b0;
  localparam logic VARIANT_FNV1A = 1'b1;

  // start value codes (code three behaves as custom seed)
  localparam logic [1:0] INIT_BASIS = 2'd0;
  localparam logic [1:0] INIT_ZERO  = 2'd1;
  localparam logic [1:0] INIT_SEED  = 2'd2;

  // primes are 2^S + small constant
  localparam int unsigned Prime32Shift  = 24;
  localparam int unsigned Prime64Shift  = 40;
  localparam int unsigned Prime128Shift = 88;
  localparam logic [8:0] PRIME32_LOW  = 9'h193;
  localparam logic [8:0] PRIME64_LOW  = 9'h1b3;
  localparam logic [8:0] PRIME128_LOW = 9'h13b;

  localparam logic [31:0]  BASIS32  = 32'h811c9dc5;
  localparam logic [63:0]  BASIS64  = 64'hcbf29ce484222325;
  localparam logic [127:0] BASIS128 = 128'h6c62272e07bb0142_62b821756295c58d;

  typedef struct packed {
    logic [1:0]  hash_width;
    logic        variant;
    logic [1:0]  init_mode;
    logic [63:0] seed_high;
    logic [63:0] seed_low;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       first_item;
  } item_t;

endpackage

// File: hdl/fnv_cfg.sv
module fnv_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [fnv_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]                 cfg_data_i,
  output fnv_pkg::cfg_t               cfg_o
);

  fnv_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        fnv_pkg::REG_HASH_WIDTH: cfg_d.hash_width = cfg_data_i[1:0];
        fnv_pkg::REG_VARIANT:    cfg_d.variant    = cfg_data_i[0];
        fnv_pkg::REG_INIT_MODE:  cfg_d.init_mode  = cfg_data_i[1:0];
        fnv_pkg::REG_SEED_HIGH:  cfg_d.seed_high  = cfg_data_i;
        fnv_pkg::REG_SEED_LOW:   cfg_d.seed_low   = cfg_data_i;
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hash_width <= fnv_pkg::WIDTH_32;
      cfg_q.variant    <= fnv_pkg::VARIANT_FNV1A;
      cfg_q.init_mode  <= fnv_pkg::INIT_BASIS;
      cfg_q.seed_high  <= 64'd0;
      cfg_q.seed_low   <= 64'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/fnv_step.sv
module fnv_step (
  input  fnv_pkg::cfg_t  cfg_i,
  input  fnv_pkg::item_t item_i,
  input  logic [127:0]   hash_i,
  output logic [127:0]   hash_o
);

  logic [127:0] start_val;
  logic [127:0] base;
  logic [127:0] byte_ext;
  logic [127:0] mul_in;
  logic [31:0]  m32;
  logic [63:0]  m64;
  logic [127:0] m128;
  logic [127:0] prod;
  logic [127:0] folded;

  // start value before width truncation
  always_comb begin
    case (cfg_i.init_mode)
      fnv_pkg::INIT_ZERO: start_val = 128'd0;
      fnv_pkg::INIT_BASIS: begin
        case (cfg_i.hash_width)
          fnv_pkg::WIDTH_32: start_val = {96'd0, fnv_pkg::BASIS32};
          fnv_pkg::WIDTH_64: start_val = {64'd0, fnv_pkg::BASIS64};
          default:           start_val = fnv_pkg::BASIS128;
        endcase
      end
      default: start_val = {cfg_i.seed_high, cfg_i.seed_low};
    endcase
  end

  // truncate to the current width, whichever source
  always_comb begin
    base = item_i.first_item ? start_val : hash_i;
    case (cfg_i.hash_width)
      fnv_pkg::WIDTH_32: base = {96'd0, base[31:0]};
      fnv_pkg::WIDTH_64: base = {64'd0, base[63:0]};
      default: ;
    endcase
  end

  assign byte_ext = {120'd0, item_i.data_byte};
  assign mul_in   = (cfg_i.variant == fnv_pkg::VARIANT_FNV1A) ? (base ^ byte_ext) : base;

  // shift plus small-constant multiply, modulo the width
  assign m32  = (mul_in[31:0] << fnv_pkg::Prime32Shift)
              + (mul_in[31:0] * fnv_pkg::PRIME32_LOW);
  assign m64  = (mul_in[63:0] << fnv_pkg::Prime64Shift)
              + (mul_in[63:0] * fnv_pkg::PRIME64_LOW);
  assign m128 = (mul_in << fnv_pkg::Prime128Shift) + (mul_in * fnv_pkg::PRIME128_LOW);

  always_comb begin
    case (cfg_i.hash_width)
      fnv_pkg::WIDTH_32: prod = {96'd0, m32};
      fnv_pkg::WIDTH_64: prod = {64'd0, m64};
      default:           prod = m128;
    endcase
  end

  assign folded = (cfg_i.variant == fnv_pkg::VARIANT_FNV1A) ? prod : (prod ^ byte_ext);
  assign hash_o = item_i.byte_valid ? folded : base;

endmodule

// File: hdl/fnv_byte_hash_engine.sv
// Path from an accepted input item to its result on the master side:
//   input register, then hash/result register.
// Throughput: one item per cycle, unless a last item waits on a stalled result register.
// Reset (rst_ni low, async): config registers return to defaults (32-bit, FNV-1a,
//   offset basis, seeds zero), running hash clears to zero, both stages empty.
module fnv_byte_hash_engine (
  input  logic         clk_i,
  input  logic         rst_ni,

  // config write channel
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i,

  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]   s_axis_tuser,   // [0] byte_valid, [1] first_item
  input  logic         s_axis_tlast,   // last_item

  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata    // [63:0] hash_high, [127:64] hash_low
);

  fnv_pkg::cfg_t  cfg;
  fnv_pkg::item_t in_item_q;
  logic           in_valid_q;
  logic           in_last_q;
  logic [127:0]   hash_q;
  logic [127:0]   hash_d;
  logic           out_valid_q;
  logic [127:0]   out_hash_q;
  logic           out_free;
  logic           advance;
  logic           s_accept;

  fnv_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Combinational fold of the registered item into the running hash.
  fnv_step u_step (
    .cfg_i  (cfg),
    .item_i (in_item_q),
    .hash_i (hash_q),
    .hash_o (hash_d)
  );

  // Output register is free if empty or being drained this cycle.
  assign out_free = !out_valid_q || m_axis_tready;

  // Items that emit nothing never wait on the result side.
  assign advance  = in_valid_q && (!in_last_q || out_free);

  // Input register refills whenever its item moves on.
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_item_q.data_byte  <= s_axis_tdata;
      in_item_q.byte_valid <= s_axis_tuser[0];
      in_item_q.first_item <= s_axis_tuser[1];
      in_last_q            <= s_axis_tlast;
    end
  end

  // running hash state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= 128'd0;
    end else if (advance) begin
      hash_q <= hash_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_hash_q <= hash_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_hash_q[63:0], out_hash_q[127:64]};

endmodule

// File: hdl/fnv_chk.sv
`include "fnv_byte_hash_engine_assert.svh"

module fnv_chk (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         s_axis_tlast,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata
);

  // results owed: last items taken in minus results taken out
  logic [1:0] pend_q, pend_d;
  logic       last_in;
  logic       res_out;

  assign last_in = s_axis_tvalid && s_axis_tready && s_axis_tlast;
  assign res_out = m_axis_tvalid && m_axis_tready;

  always_comb begin
    pend_d = pend_q;
    if (last_in && !res_out) begin
      pend_d = pend_q + 2'd1;
    end else if (res_out && !last_in) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `FNV_ASSERT_RST(a_no_result_in_reset, !rst_ni |-> !m_axis_tvalid, "result valid in reset")
  `FNV_ASSERT(a_result_owed, m_axis_tvalid |-> (pend_q != 2'd0), "result without last item")
  `FNV_ASSERT(a_pend_bound, pend_q != 2'd3, "more than two results in flight")
  `FNV_ASSERT(a_stall_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind fnv_byte_hash_engine fnv_chk u_fnv_chk (.*);
